>>> rtl/srma_pkg.sv
// srma_pkg: shared widths, register indexes and reset values for the
// spike-rejecting moving average. No dependencies.
`default_nettype none

package srma_pkg;

	// Sample and field widths (Q23.8 samples)
	localparam int DATA_W     = 32;
	localparam int WLEN_W     = 7;
	localparam int THR_W      = 24;

	// Configuration channel
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_WINDOW_LENGTH    = cfg_idx_t'(0);
	localparam cfg_idx_t REG_REJECT_THRESHOLD = cfg_idx_t'(1);

	// Register reset values
	localparam logic [WLEN_W-1:0] WLEN_RST = WLEN_W'(16);
	localparam logic [THR_W-1:0]  THR_RST  = THR_W'(7680);

	// Default store depth
	localparam int MAX_DEPTH_DEF = 64;

endpackage

`default_nettype wire

>>> rtl/srma_ram.sv
// srma_ram: generic simple dual-port RAM, one write port and one read
// port with registered read data. No dependencies.
`default_nettype none

module srma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/srma_div.sv
// srma_div: bit-serial restoring divider, unsigned, one quotient bit per
// cycle through a shift register. No dependencies.
`default_nettype none

module srma_div #(
	parameter int DW = 38,
	parameter int VW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output      logic          done,
	output      logic [DW-1:0] quotient
);

	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   dvs_q;
	logic [DW-1:0]   quo_q;   // dividend bits leave at the top, quotient bits enter below

	logic [VW:0]     trial;
	logic [VW:0]     trial_sub;
	logic            ge;

	// one restoring step
	always_comb begin
		trial     = {rem_q, quo_q[DW-1]};
		trial_sub = trial - {1'b0, dvs_q};
		ge        = (trial >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? trial_sub[VW-1:0] : trial[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/spike_rejecting_moving_average.sv
// spike_rejecting_moving_average: top level. Spike check, window pass over
// a circular store, bit-serial divide. Uses srma_pkg, srma_ram, srma_div.
//
//  channel  | signals                          | beat contents
//  ---------+----------------------------------+-----------------------------------
//  input    | s_tvalid s_tready s_tdata        | sample_in [31:0]
//  output   | m_tvalid m_tready m_tdata m_tuser| filtered_out [31:0]; sample_rejected
//  config   | cfg_valid cfg_ready cfg_index    | 0: window_length [6:0]
//           | cfg_data                         | 1: reject_threshold [23:0]
//
// Steps: the first beat after reset is accepted and goes straight to the
// output. Each later beat is accepted, checked, passed over the window
// through the RAM read port, loaded into the divider, divided bit by bit
// ending in a done step, and sent out.
// Reset: no store clearing; the window fill count starts at zero, so all
// entries read as the last output until written. Config is always ready.
// A result waiting in the output register does not block the next input.
`default_nettype none

module spike_rejecting_moving_average #(
	parameter int MAX_DEPTH = srma_pkg::MAX_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [srma_pkg::DATA_W-1:0]    s_tdata,   // [31:0] sample_in
	// output stream
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [srma_pkg::DATA_W-1:0]    m_tdata,   // [31:0] filtered_out
	output      logic [0:0]                     m_tuser,   // [0] sample_rejected
	// configuration writes
	input  wire logic                           cfg_valid,
	output      logic                           cfg_ready,
	input  wire logic [srma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [srma_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DW = srma_pkg::DATA_W;
	localparam int AW = $clog2(MAX_DEPTH);
	localparam int NW = $clog2(MAX_DEPTH + 1);
	localparam int SW = DW + $clog2(MAX_DEPTH);
	localparam int CW = (NW > srma_pkg::WLEN_W) ? NW : srma_pkg::WLEN_W;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_PASS  = 6'b000100,
		ST_DIVL  = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_HOLD  = 6'b100000
	} state_t;

	state_t st_q;

	// configuration registers
	logic [srma_pkg::WLEN_W-1:0] wlen_q;
	logic [srma_pkg::THR_W-1:0]  thr_q;

	// item state
	logic          primed_q;
	logic [DW-1:0] last_q;     // last output, also value of entries past the fill
	logic [NW-1:0] nprev_q;    // entries of the store that hold real window data
	logic [AW-1:0] base_q;     // window entry 0 is the physical slot after this one
	logic [NW-1:0] n_q;        // window length of the current item
	logic [DW-1:0] sample_q;
	logic [DW-1:0] new_q;      // value entering the window
	logic          rej_q;
	logic [DW-1:0] res_q;

	// window pass
	logic [NW-1:0] idx_q;
	logic [AW-1:0] addr_q;
	logic          vld_s1;
	logic          tail_s1;
	logic          last_s1;
	logic [AW-1:0] waddr_s1;
	logic [SW-1:0] acc_q;
	logic          neg_q;

	// output register
	logic          m_tvalid_q;
	logic [DW-1:0] m_data_q;
	logic          m_rej_q;

	logic [DW-1:0] ram_rdata;
	logic          ram_we;
	logic [DW-1:0] val;
	logic [SW-1:0] acc_next;
	logic          issue;
	logic          div_start;
	logic          div_done;
	logic [SW-1:0] div_quot;
	logic [SW-1:0] dividend;
	logic [SW-1:0] quot_signed;
	logic [NW-1:0] n_eff;
	logic [CW-1:0] wlen_ext;
	logic signed [DW:0] diff;
	logic signed [DW:0] thr_s;
	logic          out_free;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		return (a == AW'(MAX_DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	// effective window length, clamped to 1..MAX_DEPTH
	always_comb begin
		wlen_ext = CW'(wlen_q);
		if (wlen_q == '0) begin
			n_eff = NW'(1);
		end else if (wlen_ext > CW'(MAX_DEPTH)) begin
			n_eff = NW'(MAX_DEPTH);
		end else begin
			n_eff = NW'(wlen_ext);
		end
	end

	// spike check on the exact difference
	always_comb begin
		diff  = $signed({sample_q[DW-1], sample_q}) - $signed({last_q[DW-1], last_q});
		thr_s = $signed({{(DW + 1 - srma_pkg::THR_W){1'b0}}, thr_q});
	end

	// window pass: entry value, accumulate, write back filled entries
	always_comb begin
		issue    = (st_q == ST_PASS) && (idx_q < n_q);
		val      = last_s1 ? new_q : (tail_s1 ? last_q : ram_rdata);
		acc_next = acc_q + {{(SW - DW){val[DW-1]}}, val};
		ram_we   = vld_s1 && (last_s1 || tail_s1);
	end

	// divider operands and signed result
	always_comb begin
		div_start   = (st_q == ST_DIVL);
		dividend    = acc_q[SW-1] ? (~acc_q + 1'b1) : acc_q;
		quot_signed = neg_q ? (~div_quot + 1'b1) : div_quot;
		out_free    = !m_tvalid_q || m_tready;
	end

	srma_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_s1),
		.wdata (val),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	srma_div #(
		.DW (SW),
		.VW (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= srma_pkg::WLEN_RST;
			thr_q  <= srma_pkg::THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				srma_pkg::REG_WINDOW_LENGTH: begin
					wlen_q <= cfg_data[srma_pkg::WLEN_W-1:0];
				end
				srma_pkg::REG_REJECT_THRESHOLD: begin
					thr_q <= cfg_data[srma_pkg::THR_W-1:0];
				end
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			primed_q   <= 1'b0;
			last_q     <= '0;
			nprev_q    <= '0;
			base_q     <= '0;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			// the hold state reloads the output register itself
			if (m_tvalid_q && m_tready && (st_q != ST_HOLD)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (!primed_q) begin
							primed_q <= 1'b1;
							last_q   <= s_tdata;
							nprev_q  <= '0;
							st_q     <= ST_HOLD;
						end else begin
							st_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					idx_q <= '0;
					st_q  <= ST_PASS;
				end
				ST_PASS: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (vld_s1 && last_s1) begin
						st_q <= ST_DIVL;
					end
				end
				ST_DIVL: begin
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						last_q  <= quot_signed[DW-1:0];
						nprev_q <= n_q;
						base_q  <= wrap_inc(base_q);
						st_q    <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						st_q       <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_tvalid) begin
			sample_q <= s_tdata;
			n_q      <= n_eff;
			res_q    <= s_tdata;
			rej_q    <= 1'b0;
		end
		if (st_q == ST_CHECK) begin
			rej_q  <= (diff > thr_s) || (diff < -thr_s);
			new_q  <= ((diff > thr_s) || (diff < -thr_s)) ? last_q : sample_q;
			addr_q <= wrap_inc(base_q);
			acc_q  <= '0;
		end
		if (issue) begin
			addr_q   <= wrap_inc(addr_q);
			waddr_s1 <= addr_q;
			tail_s1  <= (({1'b0, idx_q} + 1'b1) >= {1'b0, nprev_q});
			last_s1  <= (idx_q == n_q - 1'b1);
		end
		if (vld_s1) begin
			acc_q <= acc_next;
		end
		if (div_start) begin
			neg_q <= acc_q[SW-1];
		end
		if (st_q == ST_DIV && div_done) begin
			res_q <= quot_signed[DW-1:0];
		end
		if (st_q == ST_HOLD && out_free) begin
			m_data_q <= res_q;
			m_rej_q  <= rej_q;
		end
	end

	assign s_tready  = (st_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_rej_q;

	// divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_DIV))
		else $error("divider done outside divide state");

	// a new result is loaded only from the hold state
	a_out_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(st_q == ST_HOLD))
		else $error("output loaded outside hold state");

	// write-back never hits the slot being read in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && issue) |-> (waddr_s1 != addr_q))
		else $error("store write and read at the same slot");

	// fill count never passes the store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nprev_q <= NW'(MAX_DEPTH))
		else $error("window fill count beyond store depth");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// tb.sv: self-checking bench for spike_rejecting_moving_average. Holds a scoreboard
// class with its own copy of the filter; depends on srma_pkg and the RTL top level.

class avg_scoreboard;
	typedef struct {
		logic signed [srma_pkg::DATA_W-1:0] value;
		logic                               rejected;
	} avg_beat_t;

	// filter state as the block should hold it
	logic signed [srma_pkg::DATA_W-1:0] taps [srma_pkg::MAX_DEPTH_DEF];
	logic signed [srma_pkg::DATA_W-1:0] last_avg;
	bit                                 primed;
	logic [srma_pkg::WLEN_W-1:0]        win_len;
	logic [srma_pkg::THR_W-1:0]         spike_thr;

	avg_beat_t expected_avgs[$];
	int        errors;

	function new();
		win_len   = srma_pkg::WLEN_RST;
		spike_thr = srma_pkg::THR_RST;
		last_avg  = '0;
		primed    = 1'b0;
		errors    = 0;
		foreach (taps[i]) taps[i] = '0;
	endfunction

	function void write_reg(srma_pkg::cfg_idx_t idx, logic [srma_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			srma_pkg::REG_WINDOW_LENGTH: win_len = data[srma_pkg::WLEN_W-1:0];
			srma_pkg::REG_REJECT_THRESHOLD: spike_thr = data[srma_pkg::THR_W-1:0];
			default: ;
		endcase
	endfunction

	// window length as the block uses it: 0 acts as 1, large values saturate
	function int clamped_len();
		int n;
		n = win_len;
		if (n < 1)
			n = 1;
		if (n > srma_pkg::MAX_DEPTH_DEF)
			n = srma_pkg::MAX_DEPTH_DEF;
		return n;
	endfunction

	// an input beat was accepted: advance the filter and queue its output
	function void note_sample(logic [srma_pkg::DATA_W-1:0] raw);
		logic signed [srma_pkg::DATA_W-1:0] s;
		avg_beat_t beat;
		int        n;
		longint    diff;
		longint    lim;
		longint    acc;
		s = raw;
		beat.rejected = 1'b0;
		if (!primed) begin
			// first sample fills the whole store and passes through
			foreach (taps[i]) taps[i] = s;
			primed = 1'b1;
			beat.value = s;
		end else begin
			n    = clamped_len();
			diff = longint'(s) - longint'(last_avg);
			lim  = longint'(spike_thr);
			for (int i = 1; i < n; i++)
				taps[i-1] = taps[i];
			// spike: replace the sample by the last output
			if (diff > lim || diff < -lim) begin
				beat.rejected = 1'b1;
				taps[n-1] = last_avg;
			end else begin
				taps[n-1] = s;
			end
			acc = 0;
			for (int i = 0; i < n; i++)
				acc += longint'(taps[i]);
			// signed divide truncates toward zero
			beat.value = 32'(acc / longint'(n));
			for (int i = n; i < srma_pkg::MAX_DEPTH_DEF; i++)
				taps[i] = beat.value;
		end
		last_avg = beat.value;
		expected_avgs.push_back(beat);
	endfunction

	task flag_mismatch(string msg);
		errors++;
		$display("tb: mismatch at %0t: %s", $realtime, msg);
	endtask

	// an output beat was accepted: compare with the oldest expected one
	task check_output(logic [srma_pkg::DATA_W-1:0] data, logic rej);
		avg_beat_t want;
		if (expected_avgs.size() == 0) begin
			flag_mismatch($sformatf("output beat %h with nothing expected", data));
			return;
		end
		want = expected_avgs.pop_front();
		if (data !== want.value)
			flag_mismatch($sformatf("filtered_out %h, expected %h", data, want.value));
		if (rej !== want.rejected)
			flag_mismatch($sformatf("sample_rejected %b, expected %b", rej, want.rejected));
	endtask

	function int pending();
		return expected_avgs.size();
	endfunction
endclass

module tb;
	localparam int DATA_W      = srma_pkg::DATA_W;
	localparam int WLEN_W      = srma_pkg::WLEN_W;
	localparam int THR_W       = srma_pkg::THR_W;
	localparam int CFG_IDX_W   = srma_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = srma_pkg::CFG_DATA_W;
	localparam int PAD_W       = CFG_DATA_W - WLEN_W;

	localparam int QUIET_LIMIT = 20000;
	localparam int PHASES      = 16;
	localparam int PHASE_BEATS = 118;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata;    // [31:0] sample_in
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DATA_W-1:0]     m_tdata;    // [31:0] filtered_out
	logic [0:0]            m_tuser;    // [0] sample_rejected
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	avg_scoreboard sb;
	int            src_idle_pct = 0;
	int            snk_stall_pct = 0;
	int            quiet_cycles = 0;

	spike_rejecting_moving_average dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// handshake monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				sb.note_sample(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_output(m_tdata, m_tuser[0]);
		end
	end

	// watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// drive one sample beat; returns on the falling edge after it was taken
	task automatic send_sample(logic [DATA_W-1:0] s);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= s;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// one register beat; valid stays high for a following write
	task automatic cfg_write(srma_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// reprogram both registers once the block is idle
	task automatic set_config(logic [WLEN_W-1:0] wl, logic [THR_W-1:0] thr);
		wait_drained();
		cfg_write(srma_pkg::REG_WINDOW_LENGTH, {PAD_W'($urandom()), wl});
		cfg_write(srma_pkg::REG_REJECT_THRESHOLD, thr);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			1: begin src_idle_pct = 62; snk_stall_pct = 0; end
			2: begin src_idle_pct = 0; snk_stall_pct = 62; end
			3: begin src_idle_pct = 6; snk_stall_pct = 6; end
			default: begin src_idle_pct = 0; snk_stall_pct = 0; end
		endcase
	endtask

	function automatic logic [DATA_W-1:0] from_last(longint d);
		return DATA_W'(longint'(sb.last_avg) + d);
	endfunction

	// mostly samples around the last output, some right at the spike limit, some wild
	function automatic logic [DATA_W-1:0] pick_sample();
		longint span;
		longint d;
		int     r;
		span = longint'(sb.spike_thr);
		r = $urandom_range(99);
		if (r < 60)
			return from_last(longint'($urandom_range(32'(2 * span))) - span);
		if (r < 75) begin
			d = span + longint'($urandom_range(1));
			return from_last($urandom_range(1) ? d : -d);
		end
		return $urandom();
	endfunction

	initial begin
		logic [WLEN_W-1:0] wl;
		logic [THR_W-1:0]  thr;
		sb        = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = srma_pkg::REG_WINDOW_LENGTH;
		cfg_data  = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: priming, then threshold edges at reset settings
		set_idling(0);
		send_sample(32'h0000_1E00);
		send_sample(from_last(7680));
		send_sample(from_last(7681));
		send_sample(from_last(-7680));
		send_sample(from_last(-7681));
		// length zero acts as one, zero threshold
		set_config(0, 0);
		send_sample(from_last(0));
		send_sample(from_last(1));
		send_sample(from_last(-1));
		// length above the store depth, widest threshold, extreme samples
		set_config(127, 24'hFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);
		// short window with small negatives: truncation toward zero
		set_config(3, 24'hFF_FFFF);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFE);
		send_sample(32'hFFFF_FFFF);
		// full depth, threshold of one LSB
		set_config(64, 1);
		send_sample(from_last(1));
		send_sample(from_last(-2));

		// random phases over settings and idling patterns
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin wl = 16; thr = 7680; end
				1: begin wl = 1; thr = 0; end
				2: begin wl = 64; thr = 24'hFF_FFFF; end
				3: begin wl = 0; thr = 1000; end
				4: begin wl = 127; thr = 300; end
				5: begin wl = 2; thr = 256; end
				default: begin
					wl  = WLEN_W'($urandom_range(127));
					thr = $urandom_range(1) ? THR_W'($urandom_range(24'hFF_FFFF))
						: THR_W'($urandom_range(4000));
				end
			endcase
			set_config(wl, thr);
			set_idling(p % 4);
			repeat (PHASE_BEATS)
				send_sample(pick_sample());
		end

		wait_drained();
		repeat (150) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

>>> filelist.f
rtl/srma_pkg.sv
rtl/srma_ram.sv
rtl/srma_div.sv
rtl/spike_rejecting_moving_average.sv
bench/tb.sv
